/* rtl/rtch_pkg.sv */
`default_nettype none
package rtch_pkg;

   localparam int CoordWidth = 32;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int OperWidth  = DiffWidth + 2;
   localparam int ProdWidth  = 2 * OperWidth;
   localparam int MinorWidth = 2 * DiffWidth + 1;
   localparam int SplitLow   = OperWidth - 1;
   localparam int DetWidth   = 104;
   localparam int RemWidth   = DetWidth + 1;
   localparam int FracBits   = 16;
   localparam int TWidth     = 31;
   localparam int CountWidth = 16;
   localparam int MatWidth   = 8;
   localparam int FifoDepth  = 2;

   localparam logic [1:0] OpLoadPrimary = 2'd0;
   localparam logic [1:0] OpLoadShadow  = 2'd1;
   localparam logic [1:0] OpTest        = 2'd2;

   // one classified item; for a load pb carries the direction, otherwise a - b
   typedef struct packed {
      logic [1:0]                       kind;
      logic [2:0][CoordWidth-1:0]       pa;
      logic [2:0][DiffWidth-1:0]        pb;
      logic [2:0][DiffWidth-1:0]        pc;
      logic [MatWidth-1:0]              material;
      logic                             last;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/rtch_front.sv */
`default_nettype none
module rtch_front (
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [295:0]         req_tdata,
   input  wire logic [1:0]           req_tuser,
   input  wire logic                 req_tlast,
   input  wire logic                 fifo_full,
   output logic                      push,
   output rtch_pkg::entry_type       entry
);

   logic op_known;
   logic is_test;
   logic signed [rtch_pkg::CoordWidth-1:0] a_v [3];
   logic signed [rtch_pkg::CoordWidth-1:0] b_v [3];
   logic signed [rtch_pkg::CoordWidth-1:0] c_v [3];

   assign op_known   = req_tuser inside {rtch_pkg::OpLoadPrimary, rtch_pkg::OpLoadShadow,
                                         rtch_pkg::OpTest};
   assign is_test    = (req_tuser == rtch_pkg::OpTest);
   assign req_tready = !fifo_full;
   // unknown codes are taken and dropped
   assign push       = req_tvalid && !fifo_full && op_known;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_v[k] = req_tdata[32*k +: 32];
         b_v[k] = req_tdata[96 + 32*k +: 32];
         c_v[k] = req_tdata[192 + 32*k +: 32];
      end
      entry.kind     = req_tuser;
      entry.material = req_tdata[295:288];
      entry.last     = req_tlast;
      for (int k = 0; k < 3; k++) begin
         entry.pa[k] = a_v[k];
         if (is_test) begin
            entry.pb[k] = {a_v[k][31], a_v[k]} - {b_v[k][31], b_v[k]};
         end else begin
            entry.pb[k] = {b_v[k][31], b_v[k]};
         end
         entry.pc[k] = {a_v[k][31], a_v[k]} - {c_v[k][31], c_v[k]};
      end
   end

endmodule
`default_nettype wire

/* rtl/rtch_fifo.sv */
`default_nettype none
module rtch_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rtch_pkg::entry_type  push_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      head_valid,
   output rtch_pkg::entry_type       head
);

   rtch_pkg::entry_type mem_ff [rtch_pkg::FifoDepth];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;

   assign full       = (cnt_ff == 2'(rtch_pkg::FifoDepth));
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/rtch_back.sv */
`default_nettype none
module rtch_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire rtch_pkg::entry_type  head,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [151:0]              rsp_tdata,
   output logic                      rsp_tuser
);

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StMul    = 4'd1;
   localparam logic [3:0] StDrain  = 4'd2;
   localparam logic [3:0] StNorm   = 4'd3;
   localparam logic [3:0] StCheck  = 4'd4;
   localparam logic [3:0] StDiv    = 4'd5;
   localparam logic [3:0] StUpd    = 4'd6;
   localparam logic [3:0] StPoint  = 4'd7;
   localparam logic [3:0] StPdrain = 4'd8;
   localparam logic [3:0] StOut    = 4'd9;

   localparam logic [1:0] TagCross = 2'd0;
   localparam logic [1:0] TagDot   = 2'd1;
   localparam logic [1:0] TagPoint = 2'd2;

   localparam int CW = rtch_pkg::CoordWidth;
   localparam int DW = rtch_pkg::DiffWidth;
   localparam int OW = rtch_pkg::OperWidth;
   localparam int PW = rtch_pkg::ProdWidth;
   localparam int MW = rtch_pkg::MinorWidth;
   localparam int XW = rtch_pkg::DetWidth;
   localparam int RW = rtch_pkg::RemWidth;
   localparam int TW = rtch_pkg::TWidth;
   localparam int FB = rtch_pkg::FracBits;
   localparam int SL = rtch_pkg::SplitLow;
   localparam int VW = XW + FB;

   function automatic logic [1:0] mod3(input logic [1:0] a, input logic [1:0] b);
      logic [2:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 3'd3) begin
         s = s - 3'd3;
      end
      return s[1:0];
   endfunction

   function automatic logic signed [DW-1:0] pick3(input logic signed [DW-1:0] v0,
                                                   input logic signed [DW-1:0] v1,
                                                   input logic signed [DW-1:0] v2,
                                                   input logic [1:0] i);
      logic signed [DW-1:0] r;
      case (i)
         2'd0:    r = v0;
         2'd1:    r = v1;
         default: r = v2;
      endcase
      return r;
   endfunction

   logic [3:0] state_ff, state_in;

   // ray and running best
   logic signed [CW-1:0] org_ff [3];
   logic signed [CW-1:0] dir_ff [3];
   logic                 shadow_mode_ff;
   logic                 best_valid_ff;
   logic [TW-1:0]        best_t_ff;
   logic [15:0]          best_index_ff;
   logic [7:0]           best_mat_ff;
   logic                 latched_ff;
   logic [rtch_pkg::CountWidth-1:0] count_ff;

   // per triangle work
   logic signed [DW-1:0] ab_ff [3];
   logic signed [DW-1:0] ac_ff [3];
   logic signed [DW-1:0] ao_ff [3];
   logic [7:0]           mat_ff;
   logic                 last_ff;
   logic signed [MW-1:0] xm_ff [3][3];
   logic signed [XW-1:0] det_ff [4];
   logic [RW-1:0]        rem_ff;
   logic [TW-1:0]        nbits_ff;
   logic [TW-1:0]        q_ff;
   logic [4:0]           div_cnt_ff;
   logic                 upd_en_ff;
   logic                 short_ff;
   logic                 sat_ff;
   logic signed [CW-1:0] pt_ff [3];

   // sequencer
   logic       phase_ff;
   logic [1:0] cc_ff;
   logic [1:0] jj_ff;
   logic       hh_ff;

   // multiplier and its tag
   logic signed [OW-1:0] opa, opb;
   logic signed [PW-1:0] prod_in, prod_ff;
   logic                 tag_vld_ff;
   logic [1:0]           tag_kind_ff;
   logic [1:0]           tag_cc_ff;
   logic [1:0]           tag_jj_ff;
   logic                 tag_hh_ff;

   logic                 rsp_valid_ff;
   logic [151:0]         rsp_data_ff;
   logic                 rsp_user_ff;
   logic                 slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign pop        = (state_ff == StIdle) && head_valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // operand selection
   always_comb begin
      logic [1:0] i_idx, k_idx;
      logic signed [DW-1:0] q_v, r_v, p_v, d_v;
      logic signed [MW-1:0] m_v;
      i_idx = mod3(jj_ff, hh_ff ? 2'd2 : 2'd1);
      k_idx = mod3(jj_ff, hh_ff ? 2'd1 : 2'd2);
      d_v   = pick3({dir_ff[0][CW-1], dir_ff[0]}, {dir_ff[1][CW-1], dir_ff[1]},
                    {dir_ff[2][CW-1], dir_ff[2]}, (state_ff == StPoint) ? jj_ff : k_idx);
      q_v   = (cc_ff == 2'd2) ? pick3(ao_ff[0], ao_ff[1], ao_ff[2], i_idx)
                              : pick3(ac_ff[0], ac_ff[1], ac_ff[2], i_idx);
      r_v   = (cc_ff == 2'd1) ? pick3(ao_ff[0], ao_ff[1], ao_ff[2], k_idx) : d_v;
      p_v   = (cc_ff == 2'd2) ? pick3(ao_ff[0], ao_ff[1], ao_ff[2], jj_ff)
                              : pick3(ab_ff[0], ab_ff[1], ab_ff[2], jj_ff);
      case (cc_ff)
         2'd1:    m_v = xm_ff[1][jj_ff];
         2'd3:    m_v = xm_ff[2][jj_ff];
         default: m_v = xm_ff[0][jj_ff];
      endcase
      if (state_ff == StPoint) begin
         opa = {{(OW-TW){1'b0}}, best_t_ff};
         opb = {{(OW-DW){d_v[DW-1]}}, d_v};
      end else if (!phase_ff) begin
         opa = {{(OW-DW){q_v[DW-1]}}, q_v};
         opb = {{(OW-DW){r_v[DW-1]}}, r_v};
      end else begin
         opa = {{(OW-DW){p_v[DW-1]}}, p_v};
         if (hh_ff) begin
            opb = {{(OW-(MW-SL)){m_v[MW-1]}}, m_v[MW-1:SL]};
         end else begin
            opb = {1'b0, m_v[SL-1:0]};
         end
      end
   end

   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      tag_kind_ff <= (state_ff == StPoint) ? TagPoint : (phase_ff ? TagDot : TagCross);
      tag_cc_ff   <= cc_ff;
      tag_jj_ff   <= jj_ff;
      tag_hh_ff   <= hh_ff;
   end

   // wide compare terms, sign normalized values
   logic signed [XW-1:0] dmb, dmbg, ntmd;
   logic signed [VW-1:0] ovf;
   logic                 hit;
   logic [RW:0]          rem2, rdiff;
   logic [TW-1:0]        tq;

   always_comb begin
      dmb  = det_ff[0] - det_ff[2];
      dmbg = det_ff[0] - det_ff[2] - det_ff[3];
      ntmd = det_ff[1] - det_ff[0];
      ovf  = {{FB{det_ff[1][XW-1]}}, det_ff[1]} - {det_ff[0][XW-1], det_ff[0], 15'b0};
      hit  = (det_ff[0] != '0) && !det_ff[1][XW-1] && (det_ff[1] != '0)
             && !det_ff[2][XW-1] && !dmb[XW-1] && !det_ff[3][XW-1] && !dmbg[XW-1];
      rem2  = {rem_ff, nbits_ff[TW-1]};
      rdiff = rem2 - {2'b0, det_ff[0]};
      tq    = sat_ff ? {TW{1'b1}} : q_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: begin
            if (head_valid && head.kind == rtch_pkg::OpTest) begin
               state_in = StMul;
            end
         end
         StMul: begin
            if (phase_ff && hh_ff && jj_ff == 2'd2 && cc_ff == 2'd3) begin
               state_in = StDrain;
            end
         end
         StDrain:  state_in = StNorm;
         StNorm:   state_in = StCheck;
         StCheck:  state_in = (hit && !latched_ff) ? StDiv : StUpd;
         StDiv:    state_in = (div_cnt_ff == 5'(TW - 1)) ? StUpd : StDiv;
         StUpd:    state_in = last_ff ? StPoint : StIdle;
         StPoint:  state_in = (jj_ff == 2'd2) ? StPdrain : StPoint;
         StPdrain: state_in = StOut;
         StOut:    state_in = slot_free ? StIdle : StOut;
         default:  state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= StIdle;
         tag_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         tag_vld_ff <= (state_ff == StMul) || (state_ff == StPoint);
      end
   end

   // sequencer counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         cc_ff    <= 2'd0;
         jj_ff    <= 2'd0;
         hh_ff    <= 1'b0;
      end else if (state_ff == StIdle || state_ff == StUpd) begin
         phase_ff <= 1'b0;
         cc_ff    <= 2'd0;
         jj_ff    <= 2'd0;
         hh_ff    <= 1'b0;
      end else if (state_ff == StPoint) begin
         jj_ff <= (jj_ff == 2'd2) ? 2'd0 : jj_ff + 2'd1;
      end else if (state_ff == StMul) begin
         hh_ff <= !hh_ff;
         if (hh_ff) begin
            if (jj_ff != 2'd2) begin
               jj_ff <= jj_ff + 2'd1;
            end else begin
               jj_ff <= 2'd0;
               if (cc_ff != (phase_ff ? 2'd3 : 2'd2)) begin
                  cc_ff <= cc_ff + 2'd1;
               end else begin
                  cc_ff    <= 2'd0;
                  phase_ff <= 1'b1;
               end
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      logic signed [47:0] psum;
      psum = {{16{org_ff[tag_jj_ff][CW-1]}}, org_ff[tag_jj_ff]}
             + {{1{prod_ff[62]}}, prod_ff[62:FB]};
      if (state_ff == StIdle && head_valid && head.kind == rtch_pkg::OpTest) begin
         for (int k = 0; k < 3; k++) begin
            ab_ff[k] <= head.pb[k];
            ac_ff[k] <= head.pc[k];
            ao_ff[k] <= {head.pa[k][CW-1], head.pa[k]} - {org_ff[k][CW-1], org_ff[k]};
         end
         mat_ff  <= head.material;
         last_ff <= head.last;
      end
      if (tag_vld_ff) begin
         case (tag_kind_ff)
            TagCross: begin
               if (!tag_hh_ff) begin
                  xm_ff[tag_cc_ff][tag_jj_ff] <= prod_ff[MW-1:0];
               end else begin
                  xm_ff[tag_cc_ff][tag_jj_ff] <= xm_ff[tag_cc_ff][tag_jj_ff] - prod_ff[MW-1:0];
               end
            end
            TagDot: begin
               logic signed [XW-1:0] term;
               term = tag_hh_ff ? {prod_ff, {SL{1'b0}}} : {{(XW-PW){prod_ff[PW-1]}}, prod_ff};
               if (tag_jj_ff == 2'd0 && !tag_hh_ff) begin
                  det_ff[tag_cc_ff] <= term;
               end else begin
                  det_ff[tag_cc_ff] <= det_ff[tag_cc_ff] + term;
               end
            end
            default: begin
               // saturate to the signed coordinate range
               if (psum[47:31] != {17{psum[47]}}) begin
                  pt_ff[tag_jj_ff] <= psum[47] ? {1'b1, {(CW-1){1'b0}}}
                                               : {1'b0, {(CW-1){1'b1}}};
               end else begin
                  pt_ff[tag_jj_ff] <= psum[CW-1:0];
               end
            end
         endcase
      end
      if (state_ff == StNorm && det_ff[0][XW-1]) begin
         for (int k = 0; k < 4; k++) begin
            det_ff[k] <= -det_ff[k];
         end
      end
      if (state_ff == StCheck) begin
         upd_en_ff  <= hit && !latched_ff;
         short_ff   <= ntmd[XW-1];
         sat_ff     <= !ovf[VW-1];
         rem_ff     <= {{(RW-(XW-15)){1'b0}}, det_ff[1][XW-1:15]};
         nbits_ff   <= {det_ff[1][14:0], {FB{1'b0}}};
         div_cnt_ff <= 5'd0;
      end
      if (state_ff == StDiv) begin
         rem_ff     <= rdiff[RW] ? rem2[RW-1:0] : rdiff[RW-1:0];
         q_ff       <= {q_ff[TW-2:0], !rdiff[RW]};
         nbits_ff   <= {nbits_ff[TW-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + 5'd1;
      end
   end

   // ray state and best hit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            org_ff[k] <= '0;
            dir_ff[k] <= '0;
         end
         shadow_mode_ff <= 1'b0;
         best_valid_ff  <= 1'b0;
         best_t_ff      <= '0;
         best_index_ff  <= '0;
         best_mat_ff    <= '0;
         latched_ff     <= 1'b0;
         count_ff       <= '0;
      end else if (state_ff == StIdle && head_valid && head.kind != rtch_pkg::OpTest) begin
         for (int k = 0; k < 3; k++) begin
            org_ff[k] <= head.pa[k];
            dir_ff[k] <= head.pb[k][CW-1:0];
         end
         shadow_mode_ff <= (head.kind == rtch_pkg::OpLoadShadow);
         best_valid_ff  <= 1'b0;
         best_t_ff      <= '0;
         best_index_ff  <= '0;
         best_mat_ff    <= '0;
         latched_ff     <= 1'b0;
         count_ff       <= '0;
      end else if (state_ff == StUpd) begin
         count_ff <= count_ff + rtch_pkg::CountWidth'(1);
         if (upd_en_ff) begin
            if (shadow_mode_ff && short_ff) begin
               latched_ff    <= 1'b1;
               best_valid_ff <= 1'b1;
               best_t_ff     <= tq;
               best_index_ff <= count_ff;
               best_mat_ff   <= mat_ff;
            end else if (!best_valid_ff || tq < best_t_ff) begin
               best_valid_ff <= 1'b1;
               best_t_ff     <= tq;
               best_index_ff <= count_ff;
               best_mat_ff   <= mat_ff;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == StOut && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StOut && slot_free) begin
         rsp_user_ff <= best_valid_ff;
         if (best_valid_ff) begin
            rsp_data_ff <= {latched_ff, pt_ff[2], pt_ff[1], pt_ff[0], best_mat_ff,
                            best_index_ff, best_t_ff};
         end else begin
            rsp_data_ff <= {latched_ff, 151'b0};
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/ray_triangle_closest_hit.sv */
`default_nettype none
// Closest-hit ray/triangle tester, signed Q16.16. A load item (primary or shadow)
// stores the ray and clears the best hit; each test item is solved exactly by
// Cramer's rule with wide integer determinants and the closest hit is kept, the
// earlier triangle winning a tie. In shadow mode the first hit with 0 < t < 1 is
// latched. A test item with tlast set gives one result transfer carrying the hit,
// t, index, material and the saturated intersection point. A test is popped, then
// the cross and dot products pass through the one shared 35x35 multiplier, then
// come drain, sign fix-up and range checks, restoring division for t and an
// update of the best hit. A miss, or any test once a shadow hit is latched,
// skips the division. When tlast is set, the point is formed on the shared
// multiplier and the result register is loaded, which then holds until
// rsp_tready. A two-entry queue sits between intake and the arithmetic so up to
// two more items transfer while a test is in flight.
module ray_triangle_closest_hit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // ax, ay, az, bx, by, bz, cx, cy, cz (32 each), material (8)
   input  wire logic [295:0]  req_tdata,
   // op
   input  wire logic [1:0]    req_tuser,
   input  wire logic          req_tlast,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // hit_t (31), tri_index (16), hit_material (8), point_x, point_y, point_z (32 each),
   // shadowed (1)
   output logic [151:0]       rsp_tdata,
   // found
   output logic               rsp_tuser
);

   logic                push;
   logic                fifo_full;
   logic                head_valid;
   logic                pop;
   rtch_pkg::entry_type push_data;
   rtch_pkg::entry_type head;

   // intake: decode op, form edge vectors
   rtch_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (push),
      .entry      (push_data)
   );

   // decouples intake from the arithmetic
   rtch_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head       (head)
   );

   // determinants, division, best-hit tracking and result register
   rtch_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

/* rtl/rtch_checker.sv */
`default_nettype none
module rtch_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [151:0]  rsp_tdata,
   input wire logic          rsp_tuser
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a miss reports all zeros
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero payload");

   // shadowed only with a hit
   a_shadow_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[151] |-> rsp_tuser)
      else $error("shadowed without hit");

endmodule

bind ray_triangle_closest_hit rtch_checker u_rtch_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
